/* sv/dwm_pkg.sv */
// shared types and constants for the display window mask unit
package dwm_pkg;

   localparam int unsigned EDGE_W   = 8;
   localparam int unsigned LINE_W   = 9;
   localparam int unsigned REQ_DW   = 24;
   localparam int unsigned RSP_DW   = 16;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned ENABLE_W = 4;

   // window_enables bits
   localparam int unsigned EN_WIN0   = 0;
   localparam int unsigned EN_WIN1   = 1;
   localparam int unsigned EN_OBJ    = 2;
   localparam int unsigned EN_ENGINE = 3;

   // flag bits
   localparam int unsigned FLAG_V = 0;
   localparam int unsigned FLAG_H = 1;
   localparam logic [1:0] FLAGS_INSIDE = 2'b11;

   typedef enum logic {
      ACT_LINE  = 1'b0,
      ACT_PIXEL = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      REG_WIN0_EDGES      = 2'd0,
      REG_WIN1_EDGES      = 2'd1,
      REG_WINDOW_CONTROLS = 2'd2,
      REG_WINDOW_ENABLES  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [EDGE_W-1:0] bottom;
      logic [EDGE_W-1:0] top;
      logic [EDGE_W-1:0] right;
      logic [EDGE_W-1:0] left;
   } edges_type;

   typedef struct packed {
      logic [EDGE_W-1:0] obj;
      logic [EDGE_W-1:0] outside;
      logic [EDGE_W-1:0] win1;
      logic [EDGE_W-1:0] win0;
   } controls_type;

   typedef struct packed {
      logic line_en;
      logic pixel_en;
   } step_type;

   typedef struct packed {
      logic              obj_window_pixel;
      logic [EDGE_W-1:0] pixel_x;
      logic [LINE_W-1:0] line_number;
   } req_payload_type;

endpackage

/* sv/dwm_window.sv */
// one rectangular window: vertical and horizontal flags and coverage
module dwm_window (
   input  logic                       clock,
   input  logic                       reset,
   input  dwm_pkg::edges_type         edges,
   input  dwm_pkg::step_type          step,
   input  logic [dwm_pkg::EDGE_W-1:0] line,
   input  logic [dwm_pkg::EDGE_W-1:0] pixel_x,
   output logic                       covered
);

   logic [1:0] flags_ff;
   logic [1:0] flags_in;
   logic [1:0] line_flags;
   logic [1:0] pixel_flags;

   always_comb begin
      line_flags = flags_ff;
      if (line == edges.bottom) begin
         line_flags[dwm_pkg::FLAG_V] = 1'b0;
      end else if (line == edges.top) begin
         line_flags[dwm_pkg::FLAG_V] = 1'b1;
      end
      pixel_flags = flags_ff;
      if (pixel_x == edges.right) begin
         pixel_flags[dwm_pkg::FLAG_H] = 1'b0;
      end else if (pixel_x == edges.left) begin
         pixel_flags[dwm_pkg::FLAG_H] = 1'b1;
      end
      flags_in = flags_ff;
      if (step.line_en) begin
         flags_in = line_flags;
      end else if (step.pixel_en) begin
         flags_in = pixel_flags;
      end
   end

   assign covered = (pixel_flags == dwm_pkg::FLAGS_INSIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= 2'b00;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

/* sv/display_window_mask_unit.sv */
// display window mask unit: top level with input stage, window flags and result register
// an accepted pixel transaction is held in the input stage, then in the result register
// throughput: one transaction per cycle unless a pending result waits on rsp_tready
// line-start transactions, if EN_ENGINE is set, update the vertical flags; no result
// synchronous active-high reset clears both pipeline valids, all flags and csr registers
// registers read back through the csr port at byte offsets 0, 4, 8 and 12
module display_window_mask_unit (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: line_number[8:0], pixel_x[16:9], obj_window_pixel[17], zero[23:18]
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dwm_pkg::REQ_DW-1:0]  req_tdata,
   // req_tuser: action[0]
   input  logic                        req_tuser,
   // rsp_tdata: window_mask[7:0], out_x[15:8]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dwm_pkg::RSP_DW-1:0]  rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [dwm_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [dwm_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [dwm_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);

   dwm_pkg::edges_type                   win0_edges_ff;
   dwm_pkg::edges_type                   win1_edges_ff;
   dwm_pkg::controls_type                controls_ff;
   logic [dwm_pkg::ENABLE_W-1:0]         enables_ff;
   dwm_pkg::reg_index_type               csr_index;
   logic                                 csr_write;

   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   dwm_pkg::action_type                  s1_action_ff;
   dwm_pkg::req_payload_type             s1_data_ff;
   logic                                 s1_advance;
   logic                                 out_free;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [dwm_pkg::EDGE_W-1:0]           mask_ff;
   logic [dwm_pkg::EDGE_W-1:0]           mask_in;
   logic [dwm_pkg::EDGE_W-1:0]           x_ff;

   dwm_pkg::step_type                    win0_step;
   dwm_pkg::step_type                    win1_step;
   logic                                 win0_inside;
   logic                                 win1_inside;
   logic                                 is_line;
   logic                                 is_pixel;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = dwm_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_edges_ff <= '0;
         win1_edges_ff <= '0;
         controls_ff   <= '0;
         enables_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            dwm_pkg::REG_WIN0_EDGES:      win0_edges_ff <= csr_pwdata;
            dwm_pkg::REG_WIN1_EDGES:      win1_edges_ff <= csr_pwdata;
            dwm_pkg::REG_WINDOW_CONTROLS: controls_ff   <= csr_pwdata;
            dwm_pkg::REG_WINDOW_ENABLES:  enables_ff    <= csr_pwdata[dwm_pkg::ENABLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dwm_pkg::REG_WIN0_EDGES:      csr_prdata = win0_edges_ff;
         dwm_pkg::REG_WIN1_EDGES:      csr_prdata = win1_edges_ff;
         dwm_pkg::REG_WINDOW_CONTROLS: csr_prdata = controls_ff;
         dwm_pkg::REG_WINDOW_ENABLES:
            csr_prdata = {{(dwm_pkg::CSR_DW-dwm_pkg::ENABLE_W){1'b0}}, enables_ff};
         default:                      csr_prdata = '0;
      endcase
   end

   // input stage
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_line    = (s1_action_ff == dwm_pkg::ACT_LINE);
   assign is_pixel   = (s1_action_ff == dwm_pkg::ACT_PIXEL);
   assign s1_advance = s1_valid_ff && (is_line || out_free);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= dwm_pkg::action_type'(req_tuser);
         s1_data_ff   <= dwm_pkg::req_payload_type'(req_tdata[$bits(dwm_pkg::req_payload_type)-1:0]);
      end
   end

   // window flags
   assign win0_step.line_en  = s1_advance && is_line && enables_ff[dwm_pkg::EN_ENGINE];
   assign win0_step.pixel_en = s1_advance && is_pixel && enables_ff[dwm_pkg::EN_WIN0];
   assign win1_step.line_en  = s1_advance && is_line && enables_ff[dwm_pkg::EN_ENGINE];
   assign win1_step.pixel_en = s1_advance && is_pixel && enables_ff[dwm_pkg::EN_WIN1];

   dwm_window u_win0 (
      .clock   (clock),
      .reset   (reset),
      .edges   (win0_edges_ff),
      .step    (win0_step),
      .line    (s1_data_ff.line_number[dwm_pkg::EDGE_W-1:0]),
      .pixel_x (s1_data_ff.pixel_x),
      .covered (win0_inside)
   );

   dwm_window u_win1 (
      .clock   (clock),
      .reset   (reset),
      .edges   (win1_edges_ff),
      .step    (win1_step),
      .line    (s1_data_ff.line_number[dwm_pkg::EDGE_W-1:0]),
      .pixel_x (s1_data_ff.pixel_x),
      .covered (win1_inside)
   );

   // priority: window 0, window 1, object window, outside
   always_comb begin
      mask_in = controls_ff.outside;
      if (enables_ff[dwm_pkg::EN_OBJ] && s1_data_ff.obj_window_pixel) begin
         mask_in = controls_ff.obj;
      end
      if (enables_ff[dwm_pkg::EN_WIN1] && win1_inside) begin
         mask_in = controls_ff.win1;
      end
      if (enables_ff[dwm_pkg::EN_WIN0] && win0_inside) begin
         mask_in = controls_ff.win0;
      end
   end

   // result register
   assign rsp_valid_in = (s1_advance && is_pixel) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && is_pixel) begin
         mask_ff <= mask_in;
         x_ff    <= s1_data_ff.pixel_x;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {x_ff, mask_ff};

   a_line_never_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && is_line) |-> s1_advance)
      else $error("line start transaction stalled in input stage");

   a_result_from_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |->
      $past(s1_valid_ff && is_pixel && s1_advance))
      else $error("result appeared without a pixel transaction");

   a_empty_stage_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("empty input stage refused a transaction");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(s1_advance && is_pixel))
      else $error("pending result overwritten");

endmodule

/* verif/tb.sv */
// testbench for the display window mask unit: stream driver, result monitor and window predictor
`timescale 1ns / 1ps

module tb;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct {
      dwm_pkg::action_type      act;
      dwm_pkg::req_payload_type pay;
   } scan_item_type;

   typedef struct {
      logic [7:0] mask;
      logic [7:0] x;
   } mask_result_type;

   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 82;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [dwm_pkg::REQ_DW-1:0]    req_tdata = '0;
   logic                          req_tuser = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [dwm_pkg::RSP_DW-1:0]    rsp_tdata;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [dwm_pkg::CSR_AW-1:0]    csr_paddr = '0;
   logic [dwm_pkg::CSR_DW-1:0]    csr_pwdata = '0;
   logic [dwm_pkg::CSR_DW-1:0]    csr_prdata;
   logic                          csr_pready;

   // window state and register copies
   dwm_pkg::edges_type            win0_cfg = '0;
   dwm_pkg::edges_type            win1_cfg = '0;
   dwm_pkg::controls_type         ctl_cfg = '0;
   logic [dwm_pkg::ENABLE_W-1:0]  en_cfg = '0;
   logic [1:0]                    win0_flags = '0;
   logic [1:0]                    win1_flags = '0;

   scan_item_type                 pending_items[$];
   mask_result_type               expected_masks[$];
   scan_item_type                 cur_item;

   int unsigned                   sender_idle_pct = 0;
   int unsigned                   receiver_stall_pct = 0;
   int unsigned                   pushed_cnt = 0;
   int unsigned                   accepted_cnt = 0;
   int unsigned                   line_cnt = 0;
   int unsigned                   pixel_cnt = 0;
   int unsigned                   checked_cnt = 0;
   int unsigned                   settings_cnt = 0;
   int unsigned                   error_cnt = 0;
   logic [7:0]                    x_run = '0;

   display_window_mask_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   task automatic report_error(input string msg);
      error_cnt++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic logic [1:0] vertical_step(input logic [1:0] flags,
                                                input dwm_pkg::edges_type e,
                                                input logic [7:0] line);
      logic [1:0] f;
      f = flags;
      if (line == e.bottom) begin
         f[dwm_pkg::FLAG_V] = 1'b0;
      end else if (line == e.top) begin
         f[dwm_pkg::FLAG_V] = 1'b1;
      end
      return f;
   endfunction

   function automatic logic [1:0] horizontal_step(input logic [1:0] flags,
                                                  input dwm_pkg::edges_type e,
                                                  input logic [7:0] x);
      logic [1:0] f;
      f = flags;
      if (x == e.right) begin
         f[dwm_pkg::FLAG_H] = 1'b0;
      end else if (x == e.left) begin
         f[dwm_pkg::FLAG_H] = 1'b1;
      end
      return f;
   endfunction

   // advances the window flags for one transaction and queues the mask a pixel produces
   function automatic void predict_window_mask(input scan_item_type it);
      mask_result_type r;
      if (it.act == dwm_pkg::ACT_LINE) begin
         line_cnt++;
         if (en_cfg[dwm_pkg::EN_ENGINE]) begin
            win0_flags = vertical_step(win0_flags, win0_cfg, it.pay.line_number[7:0]);
            win1_flags = vertical_step(win1_flags, win1_cfg, it.pay.line_number[7:0]);
         end
      end else begin
         pixel_cnt++;
         r.x = it.pay.pixel_x;
         r.mask = ctl_cfg.outside;
         if (en_cfg[dwm_pkg::EN_OBJ] && it.pay.obj_window_pixel) begin
            r.mask = ctl_cfg.obj;
         end
         if (en_cfg[dwm_pkg::EN_WIN1]) begin
            win1_flags = horizontal_step(win1_flags, win1_cfg, it.pay.pixel_x);
            if (win1_flags == dwm_pkg::FLAGS_INSIDE) begin
               r.mask = ctl_cfg.win1;
            end
         end
         if (en_cfg[dwm_pkg::EN_WIN0]) begin
            win0_flags = horizontal_step(win0_flags, win0_cfg, it.pay.pixel_x);
            if (win0_flags == dwm_pkg::FLAGS_INSIDE) begin
               r.mask = ctl_cfg.win0;
            end
         end
         expected_masks.push_back(r);
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_window_mask(cur_item);
            accepted_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               cur_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {{(dwm_pkg::REQ_DW - $bits(dwm_pkg::req_payload_type)){1'b0}},
                             cur_item.pay};
               req_tuser <= cur_item.act;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      mask_result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_masks.size() == 0) begin
               report_error($sformatf("result with no pending expectation, tdata %h",
                                      rsp_tdata));
            end else begin
               exp_r = expected_masks.pop_front();
               checked_cnt++;
               if (rsp_tdata[7:0] !== exp_r.mask) begin
                  report_error($sformatf("window_mask %h, expected %h at x %0d",
                                         rsp_tdata[7:0], exp_r.mask, exp_r.x));
               end
               if (rsp_tdata[15:8] !== exp_r.x) begin
                  report_error($sformatf("out_x %0d, expected %0d", rsp_tdata[15:8], exp_r.x));
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 48;
            receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 48;
         end
         default: begin
            sender_idle_pct = 18;
            receiver_stall_pct = 18;
         end
      endcase
   endtask

   // write a register, then read it back
   task automatic csr_write(input dwm_pkg::reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         dwm_pkg::REG_WIN0_EDGES:      win0_cfg = value;
         dwm_pkg::REG_WIN1_EDGES:      win1_cfg = value;
         dwm_pkg::REG_WINDOW_CONTROLS: ctl_cfg = value;
         default:                      en_cfg = value[dwm_pkg::ENABLE_W-1:0];
      endcase
      readback = (idx == dwm_pkg::REG_WINDOW_ENABLES) ?
                 {28'd0, value[dwm_pkg::ENABLE_W-1:0]} : value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== readback) begin
         report_error($sformatf("register %s reads %h, expected %h", idx.name(), csr_prdata,
                                readback));
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic load_settings(input logic [31:0] w0, input logic [31:0] w1,
                                input logic [31:0] ctl, input logic [3:0] en);
      csr_write(dwm_pkg::REG_WIN0_EDGES, w0);
      csr_write(dwm_pkg::REG_WIN1_EDGES, w1);
      csr_write(dwm_pkg::REG_WINDOW_CONTROLS, ctl);
      csr_write(dwm_pkg::REG_WINDOW_ENABLES, {28'd0, en});
      settings_cnt++;
   endtask

   task automatic push_item(input dwm_pkg::action_type act, input logic [8:0] line,
                            input logic [7:0] x, input logic obj);
      scan_item_type it;
      it.act = act;
      it.pay.line_number = line;
      it.pay.pixel_x = x;
      it.pay.obj_window_pixel = obj;
      pending_items.push_back(it);
      pushed_cnt++;
   endtask

   // wait until every transaction is accepted and every mask has come back
   task automatic drain;
      while (accepted_cnt != pushed_cnt || expected_masks.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_edge(input int unsigned sel);
      case (sel % 8)
         0: return win0_cfg.left;
         1: return win0_cfg.right;
         2: return win1_cfg.left;
         3: return win1_cfg.right;
         4: return win0_cfg.top;
         5: return win0_cfg.bottom;
         6: return win1_cfg.top;
         default: return win1_cfg.bottom;
      endcase
   endfunction

   task automatic push_random_item;
      logic [8:0] line;
      logic [7:0] x;
      int unsigned roll;
      line = 9'($urandom_range(511));
      x = 8'($urandom_range(255));
      if ($urandom_range(99) < 50) begin
         line = {1'($urandom_range(1)), pick_edge(4 + $urandom_range(3))};
      end
      roll = $urandom_range(99);
      if (roll < 35) begin
         x = pick_edge($urandom_range(3));
      end else if (roll < 70) begin
         x_run = x_run + 8'($urandom_range(1, 12));
         x = x_run;
      end
      if ($urandom_range(99) < 15) begin
         x_run = '0;
         push_item(dwm_pkg::ACT_LINE, line, x, 1'($urandom_range(1)));
      end else begin
         push_item(dwm_pkg::ACT_PIXEL, line, x, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic [3:0] en;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: two overlapping windows with the engine on
      set_idle(IDLE_NONE);
      load_settings(32'h0805_140A, 32'h0906_1E0F, 32'h4433_2211, 4'hF);
      push_item(dwm_pkg::ACT_LINE, 9'd5, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_LINE, 9'd262, 8'd255, 1'b1);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd10, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd15, 1'b1);
      push_item(dwm_pkg::ACT_PIXEL, 9'd511, 8'd20, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd20, 1'b1);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd30, 1'b1);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd31, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd255, 1'b1);
      push_item(dwm_pkg::ACT_LINE, 9'd264, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd10, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd15, 1'b0);
      push_item(dwm_pkg::ACT_LINE, 9'd511, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_LINE, 9'd9, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd0, 1'b1);
      drain();

      // directed: engine off, line starts must leave the flags alone
      load_settings(32'h0805_140A, 32'h0906_1E0F, 32'h4433_2211, 4'h7);
      push_item(dwm_pkg::ACT_LINE, 9'd5, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd10, 1'b1);
      push_item(dwm_pkg::ACT_LINE, 9'd0, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'd255, 1'b1);
      drain();

      // directed: coinciding edges, the clearing edge wins
      load_settings(32'h4040_4040, 32'h4040_4040, 32'hA5C3_0FF0, 4'hF);
      push_item(dwm_pkg::ACT_LINE, 9'h140, 8'd0, 1'b0);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'h40, 1'b1);
      push_item(dwm_pkg::ACT_PIXEL, 9'd0, 8'h40, 1'b0);
      drain();

      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         set_idle(idle_mode_type'(p % 4));
         if (p == 0) begin
            load_settings('1, '1, '1, 4'hF);
         end else if (p == RANDOM_PHASES - 1) begin
            load_settings('0, '0, $urandom(), 4'h0);
         end else begin
            en = 4'($urandom_range(15));
            if (p % 3 != 0) begin
               en[dwm_pkg::EN_ENGINE] = 1'b1;
            end
            load_settings($urandom(), $urandom(), $urandom(), en);
         end
         for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
            push_random_item();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (expected_masks.size() != 0) begin
         report_error($sformatf("%0d masks never arrived", expected_masks.size()));
      end
      $display("covered %0d transactions (%0d line starts, %0d pixels) under %0d settings",
               accepted_cnt, line_cnt, pixel_cnt, settings_cnt);
      $display("checked %0d masks, %0d errors", checked_cnt, error_cnt);
      if (error_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d of %0d transactions accepted", accepted_cnt, pushed_cnt);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
